/* hw/rtl/rnnf_pkg.sv */
package rnnf_pkg;

    // Default coordinate width; positions are signed Q12.4 at this width.
    localparam int COORD_WIDTH_DEF = 16;

    // Agent ids are always 16 bits wide.
    localparam int ID_WIDTH = 16;

    // Sight radius after reset, unsigned Q.4.
    localparam int RADIUS_RESET = 1600;

    // Configuration register indexes.
    localparam int REG_INDEX_WIDTH = 2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_OWN_X        = 2'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_OWN_Y        = 2'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_OWN_ID       = 2'd2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_SIGHT_RADIUS = 2'd3;

    // Result flags carried on the result channel's tuser.
    localparam int FLAG_WIDTH         = 3;
    localparam int FLAG_IN_SIGHT      = 0;
    localparam int FLAG_NEW_NEAREST   = 1;
    localparam int FLAG_NEAREST_VALID = 2;

endpackage

/* hw/rtl/rnnf_isqrt.sv */
module rnnf_isqrt #(
    parameter int ROOT_WIDTH = rnnf_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [2*ROOT_WIDTH-1:0]   radicand,
    output logic                      done,
    output logic [ROOT_WIDTH-1:0]     root
);

    localparam int CNT_W = $clog2(ROOT_WIDTH + 1);
    localparam int REM_W = ROOT_WIDTH + 1;
    localparam int TRY_W = ROOT_WIDTH + 3;

    logic [2*ROOT_WIDTH-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [ROOT_WIDTH-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [TRY_W-1:0] rem_shift;
    logic [TRY_W-1:0] trial;
    logic [TRY_W-1:0] diff;

    // One result bit per cycle: bring down the next pair of radicand bits
    // and try to subtract (4 * root + 1) from the partial remainder.
    always_comb begin
        rem_shift = {rem_reg, rad_reg[2*ROOT_WIDTH-1 -: 2]};
        trial     = TRY_W'({root_reg, 2'b01});
        diff      = rem_shift - trial;

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[2*ROOT_WIDTH-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_WIDTH-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[REM_W-1:0];
                root_next = {root_reg[ROOT_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("square root started while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("square root done while still busy");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("square root busy with an empty step count");

endmodule

/* hw/rtl/radius_neighbor_nearest_filter.sv */
// Fixed-radius neighbor filter with nearest-agent tracking.
//
// The input channel (s_) carries one other agent per item: id and Q12.4
// position in s_tdata, the end-of-frame mark in s_tlast. The result channel
// (m_) returns one item per input: heading, distance and nearest-so-far in
// m_tdata, the in-sight / new-nearest / nearest-valid flags in m_tuser and a
// copy of the frame mark in m_tlast. Registers are set through the cfg_ port;
// the user writes them only while the block is idle; the block does not enforce it.
//
// An item is worked on alone: the sum of squares is built by shift and add,
// one multiplier bit per cycle, then the square root produces one result
// bit per cycle. The result is then written to the output register, and the
// next item can be taken in the cycle after that write.
// A result that waits in the output register does not stop the next item
// from being accepted; only the following result waits for it.
// Reset clears the nearest tracking and restores the default registers.
module radius_neighbor_nearest_filter #(
    parameter int COORD_WIDTH = rnnf_pkg::COORD_WIDTH_DEF,
    localparam int CFG_W = (rnnf_pkg::ID_WIDTH > COORD_WIDTH + 1) ?
                           rnnf_pkg::ID_WIDTH : COORD_WIDTH + 1,
    localparam int S_DATA_W = ((rnnf_pkg::ID_WIDTH + 2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((6 * COORD_WIDTH + 4 + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [rnnf_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_W-1:0]                     cfg_wdata,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // other_id, other_x, other_y
    input  logic [S_DATA_W-1:0]                  s_tdata,
    input  logic                                 s_tlast,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // heading_x, heading_y, distance, nearest_x, nearest_y, nearest_distance
    output logic [M_DATA_W-1:0]                  m_tdata,
    // in_sight, new_nearest, nearest_valid
    output logic [rnnf_pkg::FLAG_WIDTH-1:0]      m_tuser,
    output logic                                 m_tlast
);

    import rnnf_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int WW      = COORD_WIDTH + 1;
    localparam int SQ_W    = 2 * COORD_WIDTH + 1;
    localparam int CNT_W   = $clog2(COORD_WIDTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_ROOT   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers.
    logic [CW-1:0]       own_x_reg;
    logic [CW-1:0]       own_y_reg;
    logic [ID_WIDTH-1:0] own_id_reg;
    logic [WW-1:0]       radius_reg;

    // Current item.
    logic [ID_WIDTH-1:0] item_id_reg;
    logic [CW-1:0]       item_x_reg;
    logic [CW-1:0]       item_y_reg;
    logic                item_last_reg;
    logic [WW-1:0]       head_x_reg;
    logic [WW-1:0]       head_y_reg;

    // Shift-and-add squaring.
    logic [2*CW-1:0] mcand_x_reg, mcand_y_reg;
    logic [CW-1:0]   mplr_x_reg, mplr_y_reg;
    logic [SQ_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] sq_cnt_reg;
    logic [SQ_W-1:0] add_x, add_y;
    logic            sq_last;

    // Nearest tracking.
    logic          best_valid_reg;
    logic [WW-1:0] best_dist_reg;
    logic [CW-1:0] best_x_reg;
    logic [CW-1:0] best_y_reg;

    // Output register.
    logic          m_tvalid_reg;
    logic          o_in_sight_reg;
    logic          o_new_nearest_reg;
    logic          o_nearest_valid_reg;
    logic [WW-1:0] o_head_x_reg;
    logic [WW-1:0] o_head_y_reg;
    logic [WW-1:0] o_dist_reg;
    logic [CW-1:0] o_near_x_reg;
    logic [CW-1:0] o_near_y_reg;
    logic [WW-1:0] o_near_dist_reg;
    logic          o_last_reg;

    logic [ID_WIDTH-1:0] in_id;
    logic [CW-1:0]       in_x, in_y;
    logic signed [WW-1:0] hx_in, hy_in;
    logic [WW-1:0]       mag_x_full, mag_y_full;
    logic                accept;
    logic                root_start, root_done;
    logic [WW-1:0]       root;
    logic                out_free, commit;
    logic                sight, newer;

    assign in_id = s_tdata[ID_WIDTH-1:0];
    assign in_x  = s_tdata[ID_WIDTH +: CW];
    assign in_y  = s_tdata[ID_WIDTH + CW +: CW];

    assign hx_in = $signed({in_x[CW-1], in_x}) - $signed({own_x_reg[CW-1], own_x_reg});
    assign hy_in = $signed({in_y[CW-1], in_y}) - $signed({own_y_reg[CW-1], own_y_reg});
    // The difference never reaches -2^CW, so the magnitude fits in CW bits.
    assign mag_x_full = hx_in[WW-1] ? WW'(-hx_in) : WW'(hx_in);
    assign mag_y_full = hy_in[WW-1] ? WW'(-hy_in) : WW'(hy_in);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign add_x    = mplr_x_reg[0] ? SQ_W'(mcand_x_reg) : '0;
    assign add_y    = mplr_y_reg[0] ? SQ_W'(mcand_y_reg) : '0;
    assign acc_next = acc_reg + add_x + add_y;
    assign sq_last  = (sq_cnt_reg == CNT_W'(CW - 1));

    assign root_start = (state_reg == ST_SQUARE) && sq_last;

    rnnf_isqrt #(
        .ROOT_WIDTH (WW)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand ((2 * WW)'(acc_next)),
        .done     (root_done),
        .root     (root)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_COMMIT) && out_free;

    assign sight = (item_id_reg != own_id_reg) && (root < radius_reg);
    assign newer = sight && (!best_valid_reg || (root < best_dist_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (sq_last) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            own_x_reg      <= '0;
            own_y_reg      <= '0;
            own_id_reg     <= '0;
            radius_reg     <= WW'(RADIUS_RESET);
            best_valid_reg <= 1'b0;
            best_dist_reg  <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            sq_cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_OWN_X:        own_x_reg  <= cfg_wdata[CW-1:0];
                    REG_OWN_Y:        own_y_reg  <= cfg_wdata[CW-1:0];
                    REG_OWN_ID:       own_id_reg <= cfg_wdata[ID_WIDTH-1:0];
                    REG_SIGHT_RADIUS: radius_reg <= cfg_wdata[WW-1:0];
                endcase
            end

            if (accept) begin
                sq_cnt_reg <= '0;
            end else if (state_reg == ST_SQUARE) begin
                sq_cnt_reg <= sq_cnt_reg + CNT_W'(1);
            end

            // The frame's last item shows its own tracking, then clears it.
            if (commit) begin
                if (item_last_reg) begin
                    best_valid_reg <= 1'b0;
                    best_dist_reg  <= '0;
                    best_x_reg     <= '0;
                    best_y_reg     <= '0;
                end else if (newer) begin
                    best_valid_reg <= 1'b1;
                    best_dist_reg  <= root;
                    best_x_reg     <= item_x_reg;
                    best_y_reg     <= item_y_reg;
                end
            end

            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_id_reg   <= in_id;
            item_x_reg    <= in_x;
            item_y_reg    <= in_y;
            item_last_reg <= s_tlast;
            head_x_reg    <= WW'(hx_in);
            head_y_reg    <= WW'(hy_in);
            mcand_x_reg   <= (2 * CW)'(mag_x_full[CW-1:0]);
            mcand_y_reg   <= (2 * CW)'(mag_y_full[CW-1:0]);
            mplr_x_reg    <= mag_x_full[CW-1:0];
            mplr_y_reg    <= mag_y_full[CW-1:0];
            acc_reg       <= '0;
        end else if (state_reg == ST_SQUARE) begin
            mcand_x_reg <= {mcand_x_reg[2*CW-2:0], 1'b0};
            mcand_y_reg <= {mcand_y_reg[2*CW-2:0], 1'b0};
            mplr_x_reg  <= {1'b0, mplr_x_reg[CW-1:1]};
            mplr_y_reg  <= {1'b0, mplr_y_reg[CW-1:1]};
            acc_reg     <= acc_next;
        end

        if (commit) begin
            o_in_sight_reg      <= sight;
            o_new_nearest_reg   <= newer;
            o_nearest_valid_reg <= newer || best_valid_reg;
            o_head_x_reg        <= head_x_reg;
            o_head_y_reg        <= head_y_reg;
            o_dist_reg          <= root;
            // The held entry is all zeros whenever nothing is held.
            o_near_x_reg        <= newer ? item_x_reg : best_x_reg;
            o_near_y_reg        <= newer ? item_y_reg : best_y_reg;
            o_near_dist_reg     <= newer ? root : best_dist_reg;
            o_last_reg          <= item_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({o_near_dist_reg, o_near_y_reg, o_near_x_reg,
                                 o_dist_reg, o_head_y_reg, o_head_x_reg});
    assign m_tlast  = o_last_reg;

    always_comb begin
        m_tuser                     = '0;
        m_tuser[FLAG_IN_SIGHT]      = o_in_sight_reg;
        m_tuser[FLAG_NEW_NEAREST]   = o_new_nearest_reg;
        m_tuser[FLAG_NEAREST_VALID] = o_nearest_valid_reg;
    end

    a_new_in_sight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && o_new_nearest_reg) |-> o_in_sight_reg)
        else $error("new nearest reported for an item out of sight");

    a_new_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && o_new_nearest_reg) |-> (o_near_dist_reg == o_dist_reg))
        else $error("new nearest distance differs from the item distance");

    a_sight_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && o_in_sight_reg) |-> o_nearest_valid_reg)
        else $error("item in sight but no nearest reported");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && item_last_reg) |=> !best_valid_reg)
        else $error("nearest tracking not cleared after the last item");

    a_root_in_time: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside the root phase");

endmodule

/* tb/sv/radius_neighbor_checker.sv */
module radius_neighbor_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [rnnf_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [16:0]                          cfg_wdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // other_id, other_x, other_y
    input  logic [47:0]                          s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // heading_x, heading_y, distance, nearest_x, nearest_y, nearest_distance
    input  logic [103:0]                         m_tdata,
    // in_sight, new_nearest, nearest_valid
    input  logic [rnnf_pkg::FLAG_WIDTH-1:0]      m_tuser,
    input  logic                                 m_tlast,
    output int                                   mismatches,
    output int                                   outstanding
);

    import rnnf_pkg::*;

    typedef struct {
        logic        in_sight;
        logic [16:0] heading_x;
        logic [16:0] heading_y;
        logic [16:0] distance;
        logic        new_nearest;
        logic        nearest_valid;
        logic [15:0] nearest_x;
        logic [15:0] nearest_y;
        logic [16:0] nearest_distance;
        logic        frame_end;
    } sight_report_t;

    sight_report_t sight_reports[$];

    logic [15:0] own_x;
    logic [15:0] own_y;
    logic [15:0] own_id;
    logic [16:0] sight_radius;

    logic        held_valid;
    logic [16:0] held_distance;
    logic [15:0] held_x;
    logic [15:0] held_y;

    int fail_total = 0;
    int result_index = 0;

    task automatic report_mismatch(input string msg);
        $display("[checker] %s", msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [16:0] got,
                               input logic [16:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%h, want 0x%h",
                                      result_index, name, got, want));
        end
    endtask

    // Appends one expected result behind those still pending.
    task automatic queue_report(input sight_report_t rep);
        sight_reports = {sight_reports, rep};
    endtask

    // Works out the result of one agent and advances the nearest tracking.
    task automatic track_neighbor(input logic [15:0] id, input logic [15:0] x,
                                  input logic [15:0] y, input logic last,
                                  output sight_report_t rep);
        logic signed [16:0] hx;
        logic signed [16:0] hy;
        longint             sq;
        longint             root;
        logic               sight;
        logic               closer;
        hx = $signed({x[15], x}) - $signed({own_x[15], own_x});
        hy = $signed({y[15], y}) - $signed({own_y[15], own_y});
        sq = longint'(hx) * longint'(hx) + longint'(hy) * longint'(hy);
        // The real square root is only a first guess; the two loops make it exact.
        root = longint'($floor($sqrt(real'(sq))));
        while (root * root > sq) root--;
        while ((root + 1) * (root + 1) <= sq) root++;
        sight = (id != own_id) && (root < longint'(sight_radius));
        closer = sight && (!held_valid || root < longint'(held_distance));
        if (closer) begin
            held_valid = 1'b1;
            held_distance = root[16:0];
            held_x = x;
            held_y = y;
        end
        rep.in_sight = sight;
        rep.heading_x = hx;
        rep.heading_y = hy;
        rep.distance = root[16:0];
        rep.new_nearest = closer;
        rep.nearest_valid = held_valid;
        rep.nearest_x = held_x;
        rep.nearest_y = held_y;
        rep.nearest_distance = held_distance;
        rep.frame_end = last;
        if (last) begin
            held_valid = 1'b0;
            held_distance = '0;
            held_x = '0;
            held_y = '0;
        end
    endtask

    always @(posedge aclk) begin : watch
        sight_report_t rep;
        sight_report_t want;
        if (!aresetn) begin
            own_x = '0;
            own_y = '0;
            own_id = '0;
            sight_radius = 17'(RADIUS_RESET);
            held_valid = 1'b0;
            held_distance = '0;
            held_x = '0;
            held_y = '0;
            sight_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_OWN_X: own_x = cfg_wdata[15:0];
                    REG_OWN_Y: own_y = cfg_wdata[15:0];
                    REG_OWN_ID: own_id = cfg_wdata[15:0];
                    REG_SIGHT_RADIUS: sight_radius = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (sight_reports.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item pending",
                                              result_index));
                end else begin
                    want = sight_reports.pop_front();
                    check_field("heading_x", m_tdata[16:0], want.heading_x);
                    check_field("heading_y", m_tdata[33:17], want.heading_y);
                    check_field("distance", m_tdata[50:34], want.distance);
                    check_field("nearest_x", 17'(m_tdata[66:51]), 17'(want.nearest_x));
                    check_field("nearest_y", 17'(m_tdata[82:67]), 17'(want.nearest_y));
                    check_field("nearest_distance", m_tdata[99:83], want.nearest_distance);
                    check_field("tdata padding", 17'(m_tdata[103:100]), 17'd0);
                    check_field("in_sight", 17'(m_tuser[FLAG_IN_SIGHT]), 17'(want.in_sight));
                    check_field("new_nearest", 17'(m_tuser[FLAG_NEW_NEAREST]),
                                17'(want.new_nearest));
                    check_field("nearest_valid", 17'(m_tuser[FLAG_NEAREST_VALID]),
                                17'(want.nearest_valid));
                    check_field("tlast", 17'(m_tlast), 17'(want.frame_end));
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                track_neighbor(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tlast, rep);
                queue_report(rep);
            end
        end
        outstanding <= sight_reports.size();
        mismatches <= fail_total;
    end

endmodule

/* tb/sv/radius_neighbor_nearest_filter_test.sv */
module radius_neighbor_nearest_filter_test;
    import rnnf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT = 5000;
    localparam int SEGMENTS = 12;
    localparam int SEGMENT_ITEMS = 153;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [REG_INDEX_WIDTH-1:0] cfg_index = REG_OWN_X;
    logic [16:0]                cfg_wdata = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [47:0]                s_tdata = '0;
    logic                       s_tlast = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [103:0]               m_tdata;
    logic [FLAG_WIDTH-1:0]      m_tuser;
    logic                       m_tlast;

    int mismatches;
    int outstanding;
    int send_gap_pct = 9;
    int stall_pct = 85;
    int quiet_cycles = 0;

    logic [15:0] own_x_set = '0;
    logic [15:0] own_y_set = '0;
    logic [15:0] own_id_set = '0;

    radius_neighbor_nearest_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    radius_neighbor_checker results_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[radius_neighbor_nearest_filter] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [15:0] id, input logic [15:0] x,
                             input logic [15:0] y, input logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x, id};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every result is back and the block has had time to go quiet.
    task automatic settle_block;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [16:0] x, input logic [16:0] y,
                              input logic [16:0] id, input logic [16:0] radius);
        cfg_we <= 1'b1;
        cfg_index <= REG_OWN_X;
        cfg_wdata <= x;
        @(posedge aclk);
        cfg_index <= REG_OWN_Y;
        cfg_wdata <= y;
        @(posedge aclk);
        cfg_index <= REG_OWN_ID;
        cfg_wdata <= id;
        @(posedge aclk);
        cfg_index <= REG_SIGHT_RADIUS;
        cfg_wdata <= radius;
        @(posedge aclk);
        cfg_we <= 1'b0;
        own_x_set = x[15:0];
        own_y_set = y[15:0];
        own_id_set = id[15:0];
    endtask

    // Frames of a few agents, mostly placed around the own position so that
    // sight and nearest tracking are exercised; some noise on ids and frame ends.
    task automatic random_segment(input int count, input int span);
        int          frame_left;
        int          roll;
        logic [15:0] id;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        frame_left = 0;
        for (int i = 0; i < count; i++) begin
            if (frame_left == 0) frame_left = $urandom_range(1, 12);
            roll = $urandom_range(0, 99);
            id = (roll < 8) ? own_id_set : 16'($urandom);
            if (roll < 85) begin
                x = own_x_set + 16'($urandom_range(0, 2 * span) - span);
                y = own_y_set + 16'($urandom_range(0, 2 * span) - span);
            end else begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            last = (frame_left == 1) || (i == count - 1);
            if ($urandom_range(0, 99) < 4) last = ~last;
            if (last) frame_left = 0;
            else frame_left--;
            send_item(id, x, y, last);
        end
    endtask

    initial begin
        int          span;
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] id;
        logic [16:0] radius;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: own position at the origin, own id 0, radius 1600.
        send_item(16'd5, 16'd300, 16'd400, 1'b0);
        send_item(16'd0, 16'd3, 16'd4, 1'b0);
        // Same distance as the held agent must not take its place.
        send_item(16'd6, 16'hFED4, 16'hFE70, 1'b0);
        send_item(16'd8, 16'd1599, 16'd0, 1'b0);
        send_item(16'd8, 16'd1600, 16'd0, 1'b0);
        send_item(16'd1, 16'd0, 16'd48, 1'b1);
        send_item(16'd2, 16'd5, 16'd5, 1'b1);

        // Own position in one corner, two agents in the opposite one; bit 16 is ignored.
        settle_block();
        set_config(17'h18000, 17'h07FFF, 17'h1FFFF, 17'd92682);
        send_item(16'hFFFF, 16'h7FFF, 16'h8000, 1'b0);
        send_item(16'h0000, 16'h7FFF, 16'h8000, 1'b0);
        send_item(16'hAAAA, 16'h0000, 16'h0000, 1'b0);
        send_item(16'h5555, 16'h8000, 16'h7FFF, 1'b1);

        // With a zero radius nothing is in sight, not even at distance zero.
        settle_block();
        set_config(17'h07FFF, 17'h08000, 17'h00000, 17'd0);
        send_item(16'h0001, 16'h7FFF, 16'h8000, 1'b0);
        send_item(16'h1234, 16'h8000, 16'h7FFF, 1'b1);

        settle_block();
        set_config(17'h10000, 17'h10000, 17'h10000, 17'd1);
        send_item(16'h0003, 16'h0000, 16'h0000, 1'b0);
        send_item(16'h0004, 16'h0001, 16'h0000, 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle_block();
            span = $urandom_range(64, 2500);
            x = 17'($urandom);
            y = 17'($urandom);
            id = 17'($urandom);
            radius = 17'($urandom_range(0, 2 * span));
            case (seg)
                3: radius = 17'd0;
                5: begin
                    x = 17'h08000;
                    y = 17'h08000;
                    radius = 17'd92682;
                end
                7: begin
                    span = 30000;
                    radius = 17'd92682;
                end
                10: begin
                    x = 17'h07FFF;
                    y = 17'h07FFF;
                    id = 17'h00000;
                end
                11: id = 17'h0FFFF;
                default: ;
            endcase
            if (seg < 4) begin
                send_gap_pct = 9;
                stall_pct = 85;
            end else if (seg < 8) begin
                send_gap_pct = 85;
                stall_pct = 9;
            end else begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            set_config(x, y, id, radius);
            random_segment(SEGMENT_ITEMS, span);
        end

        settle_block();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[radius_neighbor_nearest_filter] OK");
        end else begin
            $display("[radius_neighbor_nearest_filter] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rnnf_pkg.sv
hw/rtl/rnnf_isqrt.sv
hw/rtl/radius_neighbor_nearest_filter.sv
tb/sv/radius_neighbor_checker.sv
tb/sv/radius_neighbor_nearest_filter_test.sv
